// File: design/mcd_pkg.sv
// Shared types, stream codes and the Morse code table for the decoder.
package mcd_pkg;

  localparam int MAX_SYMBOLS_DEF = 6;
  localparam int TABLE_LEN_W     = 4;
  localparam int TABLE_PAT_W     = 8;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] SYM_DOT  = 8'd46;
  localparam logic [7:0] SYM_DASH = 8'd45;
  localparam logic [7:0] SYM_SEP  = 8'd32;
  localparam logic [7:0] CHAR_GAP = 8'd32;

  typedef struct packed {
    logic       known;
    logic [7:0] ch;
  } mcd_token_t;

  // Match a finished token: length and dash pattern (first symbol highest).
  function automatic mcd_token_t mcd_lookup(input logic [TABLE_LEN_W-1:0] len,
                                            input logic [TABLE_PAT_W-1:0] pat);
    mcd_token_t r;
    r.known = 1'b1;
    case ({len, pat})
      12'h201: r.ch = 8'h61; // a
      12'h408: r.ch = 8'h62; // b
      12'h40A: r.ch = 8'h63; // c
      12'h304: r.ch = 8'h64; // d
      12'h100: r.ch = 8'h65; // e
      12'h402: r.ch = 8'h66; // f
      12'h306: r.ch = 8'h67; // g
      12'h400: r.ch = 8'h68; // h
      12'h200: r.ch = 8'h69; // i
      12'h407: r.ch = 8'h6A; // j
      12'h305: r.ch = 8'h6B; // k
      12'h404: r.ch = 8'h6C; // l
      12'h203: r.ch = 8'h6D; // m
      12'h202: r.ch = 8'h6E; // n
      12'h307: r.ch = 8'h6F; // o
      12'h406: r.ch = 8'h70; // p
      12'h40D: r.ch = 8'h71; // q
      12'h302: r.ch = 8'h72; // r
      12'h300: r.ch = 8'h73; // s
      12'h101: r.ch = 8'h74; // t
      12'h301: r.ch = 8'h75; // u
      12'h401: r.ch = 8'h76; // v
      12'h303: r.ch = 8'h77; // w
      12'h409: r.ch = 8'h78; // x
      12'h40B: r.ch = 8'h79; // y
      12'h40C: r.ch = 8'h7A; // z
      12'h51F: r.ch = 8'h30; // 0
      12'h50F: r.ch = 8'h31; // 1
      12'h507: r.ch = 8'h32; // 2
      12'h503: r.ch = 8'h33; // 3
      12'h501: r.ch = 8'h34; // 4
      12'h500: r.ch = 8'h35; // 5
      12'h510: r.ch = 8'h36; // 6
      12'h518: r.ch = 8'h37; // 7
      12'h51C: r.ch = 8'h38; // 8
      12'h51E: r.ch = 8'h39; // 9
      12'h512: r.ch = 8'h2F; // /
      12'h60C: r.ch = 8'h3F; // ?
      12'h633: r.ch = 8'h2C; // ,
      12'h615: r.ch = 8'h2E; // .
      12'h50A: r.ch = 8'h2B; // +
      12'h511: r.ch = 8'h3D; // =
      default: begin
        r.known = 1'b0;
        r.ch    = CHAR_GAP;
      end
    endcase
    return r;
  endfunction

endpackage

// File: design/mcd_front.sv
// Front end: gathers dots and dashes into a token and classifies it at a separator.
module mcd_front #(
  parameter int MAX_SYMBOLS = mcd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic [7:0]         in_byte,
  output logic               push,
  output mcd_pkg::mcd_token_t push_token
);
  import mcd_pkg::*;

  localparam int LEN_W = $clog2(MAX_SYMBOLS + 1);

  logic [MAX_SYMBOLS-1:0] token_pattern;
  logic [LEN_W-1:0]       token_length;
  logic                   token_invalid;
  logic                   is_sym;
  logic                   has_room;
  mcd_token_t             match;

  assign is_sym   = (in_byte == SYM_DOT) || (in_byte == SYM_DASH);
  assign has_room = token_length < LEN_W'(MAX_SYMBOLS);
  assign match    = mcd_lookup(TABLE_LEN_W'(token_length), TABLE_PAT_W'(token_pattern));

  assign push             = in_fire && (in_byte == SYM_SEP);
  assign push_token.known = match.known && !token_invalid && (token_length != '0);
  assign push_token.ch    = match.ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_pattern <= '0;
      token_length  <= '0;
      token_invalid <= 1'b0;
    end else if (in_fire) begin
      if (is_sym) begin
        if (has_room) begin
          token_pattern <= {token_pattern[MAX_SYMBOLS-2:0], in_byte == SYM_DASH};
          token_length  <= token_length + LEN_W'(1);
        end else begin
          token_invalid <= 1'b1;
        end
      end else if (in_byte == SYM_SEP) begin
        token_pattern <= '0;
        token_length  <= '0;
        token_invalid <= 1'b0;
      end else begin
        token_invalid <= 1'b1;
      end
    end
  end

endmodule

// File: design/mcd_queue.sv
// Short FIFO of classified tokens between front and back ends.
module mcd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mcd_pkg::mcd_token_t push_token,
  input  logic               pop,
  output mcd_pkg::mcd_token_t head,
  output logic               not_empty,
  output logic               full
);
  import mcd_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  mcd_token_t    mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign not_empty = count != '0;
  assign full      = count == CW'(QUEUE_DEPTH);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: design/mcd_back.sv
// Back end: applies word-gap suppression and holds the output register.
module mcd_back (
  input  logic               clk,
  input  logic               rst,
  input  mcd_pkg::mcd_token_t head,
  input  logic               not_empty,
  output logic               pop,
  output logic               out_valid,
  output logic [7:0]         out_char,
  input  logic               out_ready
);
  import mcd_pkg::*;

  logic gap_already_sent;
  logic emit;

  assign pop  = not_empty && (!out_valid || out_ready);
  assign emit = head.known || !gap_already_sent;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      gap_already_sent <= 1'b0;
    end else begin
      if (pop) begin
        out_valid        <= emit;
        gap_already_sent <= !head.known;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_char <= head.known ? head.ch : CHAR_GAP;
    end
  end

endmodule

// File: design/morse_code_decoder_unit.sv
// Top level of the Morse code decoder: front end, token queue and back end.
//
// Usage:
//   s_* is the input stream: one raw byte per transaction. '.' (46) is a dot,
//   '-' (45) a dash, ' ' (32) closes the current token; any other byte marks
//   the token unknown. m_* is the output stream: one ASCII character per
//   transaction, either a decoded letter, digit or sign, or 32 for a word gap.
//   Only a closing space can produce an output; an unknown or empty token
//   produces a gap only if no gap went out since the last character.
// Timing:
//   One byte is taken every cycle while the token queue is not full, a rate
//   set by the combinational table match in the front end. A closing space is
//   classified against the code table in its cycle, queued, and moves on to the
//   output register that drives m_tdata when the output side is free.
// Reset (rst, synchronous): clears the token under construction, the queue
//   and the output register; s_tready is high in the first cycle after reset.
// Back pressure: while m_tready is low the output register holds; tokens fill
//   the QUEUE_DEPTH-entry queue, and s_tready drops only when it is full.
module morse_code_decoder_unit #(
  parameter int MAX_SYMBOLS = mcd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [7:0] text_char
);
  import mcd_pkg::*;

  logic       in_fire;
  logic       push;
  logic       pop;
  logic       not_empty;
  logic       full;
  mcd_token_t push_token;
  mcd_token_t head;

  // Stall input only when the token queue cannot take another entry.
  assign s_tready = !full;
  assign in_fire  = s_tvalid && s_tready;

  mcd_front #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_byte   (s_tdata),
    .push      (push),
    .push_token(push_token)
  );

  mcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_token(push_token),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  mcd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .not_empty(not_empty),
    .pop      (pop),
    .out_valid(m_tvalid),
    .out_char (m_tdata),
    .out_ready(m_tready)
  );

endmodule

// File: design/mcd_checker.sv
// Port-level checks for the Morse code decoder, bound to the top level.
module mcd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);
  import mcd_pkg::*;

  logic last_was_gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_was_gap <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      last_was_gap <= m_tdata == CHAR_GAP;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("outputs not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output changed");

  a_no_double_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && last_was_gap |-> m_tdata != CHAR_GAP)
    else $error("two word gaps in a row");

  // The queue can only fill up behind a stalled output register.
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled while the output is idle");

endmodule

bind morse_code_decoder_unit mcd_checker u_mcd_checker (.*);

// File: tb/sv/tb_top.sv
// Self-checking stream testbench for the Morse code decoder unit.
module tb_top;
  import mcd_pkg::*;

  localparam int SYM_MAX     = MAX_SYMBOLS_DEF;
  localparam int NUM_CODES   = 42;
  localparam int RANDOM_ITEMS = 1800;
  localparam int HOLD_AT     = 900;   // item count at which the sender drains the block

  // Table row: a byte to send, and optionally the character it must produce.
  typedef struct {
    logic [7:0] sym;
    bit         typed;
    logic [7:0] ch;
  } row_t;

  // Per-transaction tag, handed from the driver to the input monitor.
  typedef struct {
    bit         typed;
    logic [7:0] ch;
  } tag_t;

  logic       clk;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'd0;   // [7:0] symbol_byte
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] text_char

  morse_code_decoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Code strings and the characters they stand for, in the same order.
  string code_str [NUM_CODES] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--..",
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----.",
    "-..-.", "..--..", "--..--", ".-.-.-", ".-.-.", "-...-"
  };
  string code_chr = "abcdefghijklmnopqrstuvwxyz0123456789/?,.+=";

  // Directed table: extremes, each token class, and the gap suppression rules.
  row_t dir_rows [25] = '{
    '{SYM_SEP,  1'b1, CHAR_GAP},   // empty token right after reset
    '{SYM_DOT,  1'b0, 8'd0},
    '{SYM_DASH, 1'b0, 8'd0},
    '{SYM_SEP,  1'b1, "a"},
    '{SYM_DASH, 1'b0, 8'd0},
    '{SYM_DASH, 1'b0, 8'd0},
    '{SYM_DASH, 1'b0, 8'd0},
    '{SYM_DASH, 1'b0, 8'd0},
    '{SYM_DOT,  1'b0, 8'd0},
    '{SYM_SEP,  1'b1, "9"},        // corrected nine
    '{SYM_DOT,  1'b0, 8'd0},
    '{SYM_DOT,  1'b0, 8'd0},
    '{SYM_DOT,  1'b0, 8'd0},
    '{SYM_DOT,  1'b0, 8'd0},
    '{SYM_DOT,  1'b0, 8'd0},
    '{SYM_DOT,  1'b0, 8'd0},
    '{SYM_DOT,  1'b0, 8'd0},       // one symbol too many
    '{SYM_SEP,  1'b1, CHAR_GAP},
    '{SYM_SEP,  1'b0, 8'd0},       // gap already out: nothing
    '{SYM_DASH, 1'b0, 8'd0},
    '{SYM_SEP,  1'b1, "t"},
    '{8'hFF,    1'b0, 8'd0},       // foreign byte poisons the token
    '{SYM_SEP,  1'b1, CHAR_GAP},
    '{8'h00,    1'b0, 8'd0},
    '{SYM_SEP,  1'b0, 8'd0}
  };

  // Predictor state.
  logic [SYM_MAX-1:0] tok_pat  = '0;
  logic [2:0]         tok_len  = '0;
  bit                 tok_bad  = 1'b0;
  bit                 gap_sent = 1'b0;

  logic [7:0] chars_due [$];
  tag_t       tags_due  [$];

  int  errors    = 0;
  int  n_items   = 0;
  int  n_results = 0;
  int  n_gaps    = 0;
  bit  calm      = 1'b0;   // no idling on either side while set

  // Advance the token state by one byte; report the character it releases.
  function automatic void decode_symbol(input logic [7:0] b, output bit emit,
                                        output logic [7:0] ch);
    int                 found;
    int                 len;
    logic [SYM_MAX-1:0] pat;
    emit  = 1'b0;
    ch    = CHAR_GAP;
    found = -1;
    if (b == SYM_DOT || b == SYM_DASH) begin
      if (tok_len < SYM_MAX) begin
        tok_pat = {tok_pat[SYM_MAX-2:0], b == SYM_DASH};
        tok_len = tok_len + 3'd1;
      end else begin
        tok_bad = 1'b1;
      end
      return;
    end
    if (b != SYM_SEP) begin
      tok_bad = 1'b1;
      return;
    end
    if (!tok_bad && tok_len != 0) begin
      for (int i = 0; i < NUM_CODES && found < 0; i++) begin
        len = code_str[i].len();
        pat = '0;
        for (int k = 0; k < len; k++) pat = {pat[SYM_MAX-2:0], code_str[i][k] == "-"};
        if (len == tok_len && pat == tok_pat) found = i;
      end
    end
    if (found >= 0) begin
      emit     = 1'b1;
      ch       = code_chr[found];
      gap_sent = 1'b0;
    end else if (!gap_sent) begin
      emit     = 1'b1;
      gap_sent = 1'b1;
    end
    tok_pat = '0;
    tok_len = '0;
    tok_bad = 1'b0;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3000000;
    $display("Timeout at %0t", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Input monitor predicts, output monitor checks; both sample at the rising edge.
  always @(posedge clk) begin
    bit         emit;
    logic [7:0] ch;
    tag_t       tag;
    logic [7:0] want;
    if (!rst && s_tvalid && s_tready) begin
      tag = tags_due.pop_front();
      decode_symbol(s_tdata, emit, ch);
      // A typed row overrides the predictor: its character is expected instead.
      if (tag.typed) chars_due.insert(chars_due.size(), tag.ch);
      else if (emit) chars_due.insert(chars_due.size(), ch);
    end
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (m_tdata == CHAR_GAP) n_gaps++;
      if (chars_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected text_char: expected none, actual %0d", $time, m_tdata);
      end else begin
        want = chars_due.pop_front();
        if (m_tdata !== want) begin
          errors++;
          $display("%0t: text_char mismatch: expected %0d, actual %0d",
                   $time, want, m_tdata);
        end
      end
    end
  end

  // Receiver: stall a random number of cycles, then hold ready until a transaction.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Send one byte: idle a random gap, present it, hold until accepted.
  task automatic send_byte(input logic [7:0] b, input bit typed, input logic [7:0] ch);
    int   gap;
    tag_t tag;
    gap = calm ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    tag.typed = typed;
    tag.ch    = ch;
    tags_due.insert(tags_due.size(), tag);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    n_items++;
  endtask

  task automatic send_sym(input logic [7:0] b);
    send_byte(b, 1'b0, 8'd0);
  endtask

  // Send a table code, optionally with a foreign byte slipped in, then the separator.
  task automatic send_word(input int idx, input bit poison);
    int len;
    int spot;
    len  = code_str[idx].len();
    spot = $urandom_range(0, len);
    for (int k = 0; k <= len; k++) begin
      if (poison && k == spot) send_sym(8'($urandom_range(0, 255)));
      if (k < len) send_sym(code_str[idx][k] == "-" ? SYM_DASH : SYM_DOT);
    end
    send_sym(SYM_SEP);
  endtask

  initial begin
    int sel;
    int cnt;
    bit held;
    held = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    foreach (dir_rows[i]) send_byte(dir_rows[i].sym, dir_rows[i].typed, dir_rows[i].ch);

    // Random part: mostly well-formed words, the rest broken tokens and noise.
    while (n_items < RANDOM_ITEMS) begin
      calm = ((n_items / 200) % 3) == 2;
      if (!held && n_items >= HOLD_AT) begin
        held = 1'b1;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (chars_due.size() != 0) @(posedge clk);
      end
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        send_word($urandom_range(0, NUM_CODES - 1), 1'b0);
      end else if (sel < 80) begin
        cnt = $urandom_range(1, SYM_MAX + 2);
        repeat (cnt) send_sym($urandom_range(0, 1) ? SYM_DASH : SYM_DOT);
        send_sym(SYM_SEP);
      end else if (sel < 88) begin
        send_word($urandom_range(0, NUM_CODES - 1), 1'b1);
      end else if (sel < 95) begin
        repeat ($urandom_range(1, 3)) send_sym(SYM_SEP);
      end else begin
        send_sym(8'($urandom_range(0, 255)));
      end
    end
    calm = 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b0;

    // Drain, then let the pipeline settle.
    while (chars_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (chars_due.size() != 0) begin
      errors++;
      $display("%0t: %0d expected characters never arrived", $time, chars_due.size());
    end

    $display("Sent %0d symbol bytes, checked %0d characters (%0d word gaps).",
             n_items, n_results, n_gaps);
    $display("Covered all table codes, overlong and poisoned tokens, and gap suppression.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
